// ----- hdl/mpq_pkg.sv -----
// Shared types and constants for the min priority queue.
// Used by mpq_cell and min_priority_queue_unit; depends on nothing.
package mpq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int OCC_BITS  = 5;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  // Broadcast command to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ----- hdl/mpq_cell.sv -----
// One slot of the sorted queue row: holds an entry, shifts right on insert,
// left on remove. Depends on mpq_pkg.
module mpq_cell import mpq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  entry_t    new_entry,
  input  logic      occ,
  input  logic      left_take,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      take,
  output entry_t    entry
);

  // Strict compare keeps equal priorities in arrival order.
  assign take = !occ || (new_entry.prio < entry.prio);

  always_ff @(posedge clk) begin
    if (cmd.ins && take) begin
      entry <= left_take ? left_entry : new_entry;
    end else if (cmd.rem) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- hdl/min_priority_queue_unit.sv -----
// Top level of the min priority queue: a sorted row of mpq_cell slots,
// the fill count and the result register. Depends on mpq_pkg, mpq_cell.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start & !busy      | req_type, in_priority, in_data
//  result    | done (one cycle)   | status, out_priority, out_data, occupancy
//
// One request per cycle; busy never rises. The result appears on the cycle
// after the transfer. The row stays sorted by priority, so an insert is one
// broadcast compare per cell plus a shift and a remove is a shift toward
// slot 0. Reset clears the fill count and the result strobe;
// slot contents are not cleared. The result side cannot stall.
module min_priority_queue_unit import mpq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [PRIO_BITS-1:0] in_priority,
  input  logic [DATA_BITS-1:0] in_data,
  output logic                 done,
  output logic [1:0]           status,
  output logic [PRIO_BITS-1:0] out_priority,
  output logic [DATA_BITS-1:0] out_data,
  output logic [OCC_BITS-1:0]  occupancy
);

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  status_t             result_status;
  status_t             status_next;
  cell_cmd_t           cmd;
  entry_t              new_entry;
  logic                accept;
  logic                full;
  logic                empty;

  logic   take_w  [DEPTH];
  entry_t entry_w [DEPTH];
  logic   occ_w   [DEPTH];
  logic   ltake_w [DEPTH];
  entry_t left_w  [DEPTH];
  entry_t right_w [DEPTH];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count == CNT_BITS'(DEPTH));
  assign empty     = (count == '0);
  assign new_entry = '{prio: in_priority, data: in_data};

  assign cmd.ins = accept && (req_type == REQ_INSERT) && !full;
  assign cmd.rem = accept && (req_type == REQ_REMOVE) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign occ_w[i] = (CNT_BITS'(i) < count);
      if (i == 0) begin : g_head
        assign ltake_w[i] = 1'b0;
        assign left_w[i]  = new_entry;
      end else begin : g_body
        assign ltake_w[i] = take_w[i-1];
        assign left_w[i]  = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign right_w[i] = entry_w[i];
      end else begin : g_mid
        assign right_w[i] = entry_w[i+1];
      end

      mpq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .new_entry   (new_entry),
        .occ         (occ_w[i]),
        .left_take   (ltake_w[i]),
        .left_entry  (left_w[i]),
        .right_entry (right_w[i]),
        .take        (take_w[i]),
        .entry       (entry_w[i])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = ST_INSERTED;
    if (req_type == REQ_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + CNT_BITS'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_REMOVED;
        count_next  = count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Result payload; head slot holds the minimum before the shift.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_status <= status_next;
      occupancy     <= OCC_BITS'(count_next);
      if (cmd.rem) begin
        out_priority <= entry_w[0].prio;
        out_data     <= entry_w[0].data;
      end else begin
        out_priority <= '0;
        out_data     <= '0;
      end
    end
  end

  assign status = result_status;

endmodule
